// ===== hw/rtl/cnpe_pkg.sv =====
// Shared types, codes and character tables for the cpio newc payload extractor.
`default_nettype none

package cnpe_pkg;

	localparam int unsigned NAME_LIMIT_W  = 21;
	localparam int unsigned PAY_LIMIT_W   = 48;
	localparam int unsigned COUNT_W       = 32;
	localparam int unsigned HDR_BYTES     = 104;
	localparam int unsigned MAGIC_BYTES   = 6;
	localparam int unsigned TRAILER_BYTES = 10;
	localparam int unsigned FILESIZE_FLD  = 6;
	localparam int unsigned NAMESIZE_FLD  = 11;

	localparam logic [NAME_LIMIT_W-1:0] NAME_LIMIT_RST = NAME_LIMIT_W'(1048576);
	localparam logic [PAY_LIMIT_W-1:0]  PAY_LIMIT_MAX  = {PAY_LIMIT_W{1'b1}};

	typedef enum logic [2:0] {
		PH_MAGIC    = 3'd0,
		PH_HEADER   = 3'd1,
		PH_NAME     = 3'd2,
		PH_NAMEPAD  = 3'd3,
		PH_DATA     = 3'd4,
		PH_DATAPAD  = 3'd5,
		PH_HALT     = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		ST_RUNNING   = 3'd0,
		ST_CLEAN_END = 3'd1,
		ST_TRAILER   = 3'd2,
		ST_BAD_MAGIC = 3'd3,
		ST_BAD_HEX   = 3'd4,
		ST_BAD_NAME  = 3'd5,
		ST_TRUNCATED = 3'd6,
		ST_LIMIT     = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		REG_NAME_SIZE_LIMIT = 2'd0,
		REG_PAYLOAD_LIMIT   = 2'd1
	} reg_index_t;

	// one stream item presented to the parser
	typedef struct packed {
		logic       fire;
		logic [7:0] data_byte;
		logic       stream_end;
	} step_in_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       file_last;
		status_t    status;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	function automatic logic [7:0] magic_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = "0";
			3'd1: c = "7";
			3'd2: c = "0";
			3'd3: c = "7";
			3'd4: c = "0";
			3'd5: c = "1";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] trailer_char(input logic [3:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0: c = "T";
			4'd1: c = "R";
			4'd2: c = "A";
			4'd3: c = "I";
			4'd4: c = "L";
			4'd5: c = "E";
			4'd6: c = "R";
			4'd7: c = "!";
			4'd8: c = "!";
			4'd9: c = "!";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic hex_digit_t hex_decode(input logic [7:0] b);
		hex_digit_t h;
		h.ok    = 1'b0;
		h.value = 4'h0;
		if (b >= "0" && b <= "9") begin
			h.ok    = 1'b1;
			h.value = 4'(b - "0");
		end else if (b >= "a" && b <= "f") begin
			h.ok    = 1'b1;
			h.value = 4'(b - "a" + 8'd10);
		end else if (b >= "A" && b <= "F") begin
			h.ok    = 1'b1;
			h.value = 4'(b - "A" + 8'd10);
		end
		return h;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cnpe_parser.sv =====
// Archive parser state and the combinational step logic for one stream byte.
`default_nettype none

module cnpe_parser (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  cnpe_pkg::step_in_t                     item,
	input  wire  [cnpe_pkg::NAME_LIMIT_W-1:0]      name_size_limit,
	input  wire  [cnpe_pkg::PAY_LIMIT_W-1:0]       payload_limit,
	output logic                                   res_valid,
	output cnpe_pkg::result_t                      res
);
	import cnpe_pkg::*;

	phase_t                    phase_q, phase_d;
	logic [COUNT_W-1:0]        cnt_q, cnt_d;
	logic [3:0]                fld_q, fld_d;
	logic [31:0]               acc_q, acc_d;
	logic                      stopped_q, stopped_d;
	logic [NAME_LIMIT_W-1:0]   name_len_q, name_len_d;
	logic [31:0]               file_len_q, file_len_d;
	logic                      trailer_q, trailer_d;
	logic [1:0]                off_q, off_d;
	logic [PAY_LIMIT_W-1:0]    fwd_q, fwd_d;
	logic                      magic_bad_q, magic_bad_d;
	logic                      hex_bad_q, hex_bad_d;

	logic [COUNT_W-1:0]        cnt_inc;
	logic [1:0]                off_inc;
	logic                      limit_on;
	logic                      over_now;
	logic                      over_after_inc;
	hex_digit_t                hd;
	logic [2:0]                pos;
	logic [31:0]               acc_base;
	logic                      stopped_base;
	logic [31:0]               acc_n;
	logic                      magic_bad_n;
	logic                      trailer_n;
	logic                      do_finish;
	logic                      fin_trailer;
	logic                      data_last;

	assign cnt_inc  = cnt_q + COUNT_W'(1);
	assign off_inc  = off_q + 2'd1;
	assign limit_on = (payload_limit != '0);
	assign over_now = fwd_q > payload_limit;
	// count after this byte's increment, compared without waiting on the adder
	assign over_after_inc = (fwd_q == PAY_LIMIT_MAX) ? (fwd_q > payload_limit)
		: (fwd_q >= payload_limit);
	assign hd  = hex_decode(item.data_byte);
	assign pos = cnt_q[2:0];

	always_comb begin
		phase_d     = phase_q;
		cnt_d       = cnt_q;
		fld_d       = fld_q;
		acc_d       = acc_q;
		stopped_d   = stopped_q;
		name_len_d  = name_len_q;
		file_len_d  = file_len_q;
		trailer_d   = trailer_q;
		off_d       = off_q;
		fwd_d       = fwd_q;
		magic_bad_d = magic_bad_q;
		hex_bad_d   = hex_bad_q;
		res_valid   = 1'b0;
		res         = '0;
		res.status  = ST_RUNNING;
		acc_base    = (pos == 3'd0) ? 32'd0 : acc_q;
		stopped_base = (pos == 3'd0) ? 1'b0 : stopped_q;
		acc_n       = {acc_base[27:0], hd.value};
		magic_bad_n = magic_bad_q | (item.data_byte != magic_char(cnt_q[2:0]));
		trailer_n   = trailer_q & ~((cnt_q < COUNT_W'(TRAILER_BYTES)) &&
			(item.data_byte != trailer_char(cnt_q[3:0])));
		do_finish   = 1'b0;
		fin_trailer = trailer_q;
		data_last   = (cnt_inc >= file_len_q);

		if (item.fire && phase_q != PH_HALT) begin
			if (item.stream_end) begin
				phase_d   = PH_HALT;
				res_valid = 1'b1;
				if ((phase_q == PH_MAGIC && cnt_q == '0) || phase_q == PH_DATAPAD) begin
					res.status = ST_CLEAN_END;
				end else begin
					res.status = ST_TRUNCATED;
				end
			end else begin
				off_d = off_inc;
				unique case (phase_q)
					PH_MAGIC: begin
						cnt_d       = cnt_inc;
						magic_bad_d = magic_bad_n;
						if (cnt_inc >= COUNT_W'(MAGIC_BYTES)) begin
							if (magic_bad_n) begin
								phase_d    = PH_HALT;
								res_valid  = 1'b1;
								res.status = ST_BAD_MAGIC;
							end else begin
								phase_d   = PH_HEADER;
								cnt_d     = '0;
								fld_d     = '0;
								acc_d     = '0;
								stopped_d = 1'b0;
								hex_bad_d = 1'b0;
							end
						end
					end
					PH_HEADER: begin
						acc_d     = acc_base;
						stopped_d = stopped_base;
						if (!stopped_base) begin
							if (!hd.ok) begin
								stopped_d = 1'b1;
								if (pos == 3'd0 && (fld_q == 4'(FILESIZE_FLD) ||
									fld_q == 4'(NAMESIZE_FLD))) begin
									hex_bad_d = 1'b1;
								end
							end else begin
								acc_d = acc_n;
							end
						end
						if (pos == 3'd7) begin
							if (fld_q == 4'(FILESIZE_FLD)) begin
								file_len_d = acc_d;
							end
							if (fld_q == 4'(NAMESIZE_FLD)) begin
								// sizes beyond the field width read as zero and get rejected
								name_len_d = (acc_d[31:NAME_LIMIT_W] != '0) ? '0
									: acc_d[NAME_LIMIT_W-1:0];
							end
							fld_d = fld_q + 4'd1;
						end
						cnt_d = cnt_inc;
						// last header byte cannot raise either error, so stored flags suffice
						if (cnt_inc >= COUNT_W'(HDR_BYTES)) begin
							if (hex_bad_q) begin
								phase_d    = PH_HALT;
								res_valid  = 1'b1;
								res.status = ST_BAD_HEX;
							end else if (name_len_q == '0 || name_len_q > name_size_limit) begin
								phase_d    = PH_HALT;
								res_valid  = 1'b1;
								res.status = ST_BAD_NAME;
							end else begin
								phase_d   = PH_NAME;
								cnt_d     = '0;
								trailer_d = 1'b1;
							end
						end
					end
					PH_NAME: begin
						trailer_d = trailer_n;
						cnt_d     = cnt_inc;
						if (cnt_inc >= COUNT_W'(name_len_q)) begin
							if (off_inc == 2'd0) begin
								do_finish   = 1'b1;
								fin_trailer = trailer_n;
							end else begin
								phase_d = PH_NAMEPAD;
							end
						end
					end
					PH_NAMEPAD: begin
						if (off_inc == 2'd0) begin
							do_finish = 1'b1;
						end
					end
					PH_DATA: begin
						cnt_d = cnt_inc;
						if (fwd_q != PAY_LIMIT_MAX) begin
							fwd_d = fwd_q + PAY_LIMIT_W'(1);
						end
						res_valid         = 1'b1;
						res.payload_byte  = item.data_byte;
						res.payload_valid = 1'b1;
						res.file_last     = data_last;
						if (data_last) begin
							if (limit_on && over_after_inc) begin
								phase_d    = PH_HALT;
								res.status = ST_LIMIT;
							end else if (off_inc == 2'd0) begin
								phase_d     = PH_MAGIC;
								cnt_d       = '0;
								magic_bad_d = 1'b0;
							end else begin
								phase_d = PH_DATAPAD;
							end
						end
					end
					PH_DATAPAD: begin
						if (off_inc == 2'd0) begin
							phase_d     = PH_MAGIC;
							cnt_d       = '0;
							magic_bad_d = 1'b0;
						end
					end
					default: begin
						phase_d = PH_HALT;
					end
				endcase

				// end of name and its padding: trailer, empty file or start of content
				if (do_finish) begin
					if (fin_trailer && name_len_q >= NAME_LIMIT_W'(TRAILER_BYTES)) begin
						phase_d    = PH_HALT;
						res_valid  = 1'b1;
						res.status = ST_TRAILER;
					end else if (file_len_q == '0) begin
						if (limit_on && over_now) begin
							phase_d    = PH_HALT;
							res_valid  = 1'b1;
							res.status = ST_LIMIT;
						end else if (off_inc == 2'd0) begin
							phase_d     = PH_MAGIC;
							cnt_d       = '0;
							magic_bad_d = 1'b0;
						end else begin
							phase_d = PH_DATAPAD;
						end
					end else begin
						phase_d = PH_DATA;
						cnt_d   = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_MAGIC;
			cnt_q       <= '0;
			fld_q       <= '0;
			acc_q       <= '0;
			stopped_q   <= 1'b0;
			name_len_q  <= '0;
			file_len_q  <= '0;
			trailer_q   <= 1'b1;
			off_q       <= '0;
			fwd_q       <= '0;
			magic_bad_q <= 1'b0;
			hex_bad_q   <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			cnt_q       <= cnt_d;
			fld_q       <= fld_d;
			acc_q       <= acc_d;
			stopped_q   <= stopped_d;
			name_len_q  <= name_len_d;
			file_len_q  <= file_len_d;
			trailer_q   <= trailer_d;
			off_q       <= off_d;
			fwd_q       <= fwd_d;
			magic_bad_q <= magic_bad_d;
			hex_bad_q   <= hex_bad_d;
		end
	end

`ifndef SYNTHESIS
	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |=> phase_q == PH_HALT)
		else $error("parser left halt without reset");
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(item.fire && phase_q == PH_HALT) |-> !res_valid)
		else $error("result produced while halted");
	a_payload_from_data: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.payload_valid) |-> (phase_q == PH_DATA && !item.stream_end))
		else $error("content byte forwarded outside data phase");
	a_result_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status != ST_RUNNING) |=> phase_q == PH_HALT)
		else $error("status reported without halting");
	a_field_index: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> fld_q <= 4'd13)
		else $error("header field index past the last field");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/cpio_newc_payload_extractor_core.sv =====
// Pipeline: an accepted item is registered, parsed once the output register is free, and its
// result is held in the output register until the downstream takes it.
// Throughput: one archive byte per cycle while the output register is not stalled by m_axis_tready.
// Reset (arst_n low, asynchronous): parser back to expecting magic, pipeline empty,
// name_size_limit = 1048576 and payload_limit = 0.
`default_nettype none

module cpio_newc_payload_extractor_core (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [7:0]   s_axis_tdata,   // [7:0] data_byte
	input  wire          s_axis_tuser,   // [0] stream_end
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	output logic [7:0]   m_axis_tdata,   // [7:0] payload_byte
	output logic         m_axis_tlast,   // file_last
	output logic [3:0]   m_axis_tuser,   // [0] payload_valid, [3:1] status
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [1:0]   cfg_index,
	input  wire  [47:0]  cfg_data
);
	import cnpe_pkg::*;

	logic                     valid_s1;
	logic [7:0]               byte_s1;
	logic                     end_s1;
	logic                     out_free;
	logic                     s_fire;
	step_in_t                 item;
	logic                     res_valid;
	result_t                  res;
	result_t                  out_q;
	logic                     out_valid_q;
	logic [NAME_LIMIT_W-1:0]  name_limit_q;
	logic [PAY_LIMIT_W-1:0]   pay_limit_q;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || out_free;
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	assign item.fire       = valid_s1 && out_free;
	assign item.data_byte  = byte_s1;
	assign item.stream_end = end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_limit_q <= NAME_LIMIT_RST;
			pay_limit_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NAME_SIZE_LIMIT: name_limit_q <= cfg_data[NAME_LIMIT_W-1:0];
				REG_PAYLOAD_LIMIT:   pay_limit_q  <= cfg_data[PAY_LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	cnpe_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.item            (item),
		.name_size_limit (name_limit_q),
		.payload_limit   (pay_limit_q),
		.res_valid       (res_valid),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= item.fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.fire && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.payload_byte;
	assign m_axis_tlast  = out_q.file_last;
	assign m_axis_tuser  = {out_q.status, out_q.payload_valid};

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !item.fire)
		else $error("parser stepped while result register was held");
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(byte_s1) && $stable(end_s1)))
		else $error("input stage lost a stalled item");
	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("empty input stage refused an item");
`endif

endmodule

`default_nettype wire
